[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers, clocked on aclk and gated by reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that trigger implies prop in the same cycle.
`define ASSERT_IMPLY(label, trigger, prop, msg) \
    `ASSERT_CLK(label, (trigger) |-> (prop), msg)

`endif

[hw/rtl/b64d_pkg.sv]
package b64d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned GROUP_BYTES = 3;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    // Offsets that move each character range onto its sextet range.
    localparam logic [7:0] OFS_UPPER = 8'h41;
    localparam logic [7:0] OFS_LOWER = 8'h47;
    localparam logic [7:0] OFS_DIGIT = 8'h04;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic                          is_alpha;
        logic [SEXTET_W-1:0]           value;
    } sextet_t;

    typedef struct packed {
        logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                         last_idx;
        logic                               has_bytes;
        logic                               msg_end;
    } job_t;

    function automatic sextet_t char_to_sextet(input logic [7:0] c);
        sextet_t r;
        r.is_alpha = 1'b1;
        r.value    = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r.value = 6'(c - OFS_UPPER);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r.value = 6'(c - OFS_LOWER);
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r.value = 6'(c + OFS_DIGIT);
        end else if (c == CHAR_PLUS) begin
            r.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            r.value = SEXTET_SLASH;
        end else begin
            r.is_alpha = 1'b0;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b64d_front.sv]
module b64d_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_char,
    input  logic               s_final_char,
    input  logic               q_full,
    output logic               job_push,
    output b64d_pkg::job_t     job
);

    logic [1:0]                  count_reg, count_next;
    logic                        stopped_reg, stopped_next;
    logic [b64d_pkg::SEXTET_W-1:0] held_reg [3];

    b64d_pkg::sextet_t           sx;
    logic                        take;
    logic                        live;
    logic                        full_group;
    logic                        flush;
    logic [2:0]                  eff_count;
    logic [1:0]                  nbytes;
    logic [b64d_pkg::SEXTET_W-1:0] e0, e1, e2;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign sx      = b64d_pkg::char_to_sextet(s_text_char);
    assign live    = !stopped_reg && sx.is_alpha;

    assign e0 = (live && count_reg == 2'd0) ? sx.value : held_reg[0];
    assign e1 = (live && count_reg == 2'd1) ? sx.value : held_reg[1];
    assign e2 = (live && count_reg == 2'd2) ? sx.value : held_reg[2];

    assign full_group = live && count_reg == 2'd3;
    assign flush      = (!stopped_reg && !sx.is_alpha) || s_final_char;
    assign eff_count  = live ? ({1'b0, count_reg} + 3'd1) : {1'b0, count_reg};

    always_comb begin
        if (full_group) begin
            nbytes = 2'd3;
        end else if (flush && eff_count >= 3'd2) begin
            nbytes = 2'(eff_count - 3'd1);
        end else begin
            nbytes = 2'd0;
        end
    end

    always_comb begin
        job.bytes[0]  = {e0, e1[5:4]};
        job.bytes[1]  = {e1[3:0], e2[5:2]};
        job.bytes[2]  = {e2[1:0], sx.value};
        job.has_bytes = nbytes != 2'd0;
        job.last_idx  = (nbytes != 2'd0) ? nbytes - 2'd1 : 2'd0;
        job.msg_end   = s_final_char;
    end

    assign job_push = take && (nbytes != 2'd0 || s_final_char);

    always_comb begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (take) begin
            if (s_final_char) begin
                count_next   = 2'd0;
                stopped_next = 1'b0;
            end else if (!stopped_reg) begin
                if (sx.is_alpha) begin
                    count_next = (count_reg == 2'd3) ? 2'd0 : count_reg + 2'd1;
                end else begin
                    count_next   = 2'd0;
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 2'd0;
            stopped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && live && count_reg != 2'd3) begin
            held_reg[count_reg] <= sx.value;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
module b64d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output b64d_pkg::job_t head_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64d_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full       = fill_reg == FULL_CNT;
    assign head_valid = fill_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/b64d_back.sv]
module b64d_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  b64d_pkg::job_t head_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_data_out,
    output logic           m_byte_valid,
    output logic           m_message_end,
    output logic           m_last_in_run
);

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] data_reg;
    logic       byte_valid_reg, msg_end_reg, last_reg;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign at_last = idx_reg == head_job.last_idx;
    assign pop     = load && at_last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = at_last ? 2'd0 : idx_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg       <= head_job.has_bytes ? head_job.bytes[idx_reg] : 8'd0;
            byte_valid_reg <= head_job.has_bytes;
            msg_end_reg    <= head_job.msg_end && at_last;
            last_reg       <= at_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_out    = data_reg;
    assign m_byte_valid  = byte_valid_reg;
    assign m_message_end = msg_end_reg;
    assign m_last_in_run = last_reg;

endmodule

[hw/rtl/base64_decoder_unit.sv]
// Channel   Direction  Ports
// s_        in         s_valid s_ready s_text_char s_final_char
// m_        out        m_valid m_ready m_data_out m_byte_valid m_message_end m_last_in_run
//
// One character is taken per cycle while the job queue has room.
// Each job yields one to three transfers on m_, one per cycle from the output register while m_ready is high.
// A character's result passes through the job queue and then the output register before it shows on m_.
// Reset is synchronous on aresetn low and clears counters, flags and queue pointers.
// A stall on m_ backs up the queue; s_ready drops only when the queue is full.
`include "assert_macros.svh"

module base64_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_char,
    input  logic       s_final_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_out,
    output logic       m_byte_valid,
    output logic       m_message_end,
    output logic       m_last_in_run
);

    b64d_pkg::job_t push_job, head_job;
    logic           job_push, q_full, q_pop, q_valid;

    b64d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_char  (s_text_char),
        .s_final_char (s_final_char),
        .q_full       (q_full),
        .job_push     (job_push),
        .job          (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_valid),
        .head_job      (head_job),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_byte_valid  (m_byte_valid),
        .m_message_end (m_message_end),
        .m_last_in_run (m_last_in_run)
    );

    `ASSERT_IMPLY(a_end_is_last, m_valid && m_message_end, m_last_in_run, "message end not last in run")
    `ASSERT_IMPLY(a_empty_result, m_valid && !m_byte_valid, m_data_out == 8'd0 && m_message_end && m_last_in_run, "empty result malformed")
    `ASSERT_IMPLY(a_no_overflow, q_full, !s_ready, "input taken while queue full")
    `ASSERT_IMPLY(a_pop_has_data, q_pop, q_valid, "pop from empty queue")

endmodule

[test/base64_decoder_unit_tb.sv]
`timescale 1ns / 1ps

module base64_decoder_unit_tb;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam int RANDOM_CHARS = 500;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       message_end;
        logic       last_in_run;
    } decoded_byte_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         typed;
        int         nbytes;
        logic [7:0] bytes [3];
    } char_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_char = 8'h00;
    logic       s_final_char = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_out;
    logic       m_byte_valid;
    logic       m_message_end;
    logic       m_last_in_run;

    logic [1:0]    grp_count;
    logic [5:0]    grp_sextets [3];
    logic          halted;
    decoded_byte_t step_out [$];
    decoded_byte_t pending_bytes [$];
    char_item_t    stim_q [$];
    int            mismatch_count = 0;

    char_item_t directed_rows [25] = '{
        '{CHAR_PAD, 1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"A",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"A",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"A",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"A",      1'b0, 1'b1, 3, '{8'h00, 8'h00, 8'h00}},
        '{"/",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"/",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"/",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"/",      1'b0, 1'b1, 3, '{8'hFF, 8'hFF, 8'hFF}},
        '{"Z",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"z",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"0",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"9",      1'b1, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"+",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"Q",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{CHAR_PAD, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{8'hFF,    1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"A",      1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"B",      1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{8'h80,    1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{8'h00,    1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
        '{"a",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"b",      1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{"c",      1'b1, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
        '{8'h7F,    1'b1, 1'b1, 0, '{8'h00, 8'h00, 8'h00}}
    };

    base64_decoder_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_final_char  (s_final_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_byte_valid  (m_byte_valid),
        .m_message_end (m_message_end),
        .m_last_in_run (m_last_in_run)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] sextet_of(logic [7:0] c);
        if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
            return {1'b0, 6'(c - b64d_pkg::CHAR_UPPER_A)};
        end
        if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
            return {1'b0, 6'(c - b64d_pkg::CHAR_LOWER_A + 8'd26)};
        end
        if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
            return {1'b0, 6'(c - b64d_pkg::CHAR_DIGIT_0 + 8'd52)};
        end
        if (c == b64d_pkg::CHAR_PLUS) begin
            return 7'd62;
        end
        if (c == b64d_pkg::CHAR_SLASH) begin
            return 7'd63;
        end
        return 7'h40;
    endfunction

    function automatic logic [7:0] alpha_char(int v);
        if (v < 26) begin
            return b64d_pkg::CHAR_UPPER_A + 8'(v);
        end
        if (v < 52) begin
            return b64d_pkg::CHAR_LOWER_A + 8'(v - 26);
        end
        if (v < 62) begin
            return b64d_pkg::CHAR_DIGIT_0 + 8'(v - 52);
        end
        return (v == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        step_out.insert(step_out.size(), '{b, 1'b1, 1'b0, 1'b0});
    endfunction

    function automatic void flush_group();
        if (grp_count >= 2) begin
            emit_byte({grp_sextets[0], grp_sextets[1][5:4]});
        end
        if (grp_count == 3) begin
            emit_byte({grp_sextets[1][3:0], grp_sextets[2][5:2]});
        end
        grp_count = 2'd0;
    endfunction

    function automatic void predict_char(logic [7:0] ch, logic fin);
        logic [6:0] sx;
        step_out.delete();
        if (!halted) begin
            sx = sextet_of(ch);
            if (sx[6]) begin
                flush_group();
                halted = 1'b1;
            end else if (grp_count < 3) begin
                grp_sextets[grp_count] = sx[5:0];
                grp_count = grp_count + 2'd1;
            end else begin
                emit_byte({grp_sextets[0], grp_sextets[1][5:4]});
                emit_byte({grp_sextets[1][3:0], grp_sextets[2][5:2]});
                emit_byte({grp_sextets[2][1:0], sx[5:0]});
                grp_count = 2'd0;
            end
        end
        if (fin) begin
            flush_group();
            if (step_out.size() == 0) begin
                step_out.insert(0, '{8'h00, 1'b0, 1'b0, 1'b0});
            end
            step_out[step_out.size() - 1].message_end = 1'b1;
            halted = 1'b0;
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last_in_run = 1'b1;
        end
    endfunction

    function automatic void push_typed(char_item_t it);
        decoded_byte_t run [$];
        for (int i = 0; i < it.nbytes; i++) begin
            run.insert(run.size(), '{it.bytes[i], 1'b1, 1'b0, 1'b0});
        end
        if (it.fin && run.size() == 0) begin
            run.insert(0, '{8'h00, 1'b0, 1'b0, 1'b0});
        end
        if (run.size() > 0) begin
            run[run.size() - 1].message_end = it.fin;
            run[run.size() - 1].last_in_run = 1'b1;
        end
        foreach (run[i]) begin
            pending_bytes.insert(pending_bytes.size(), run[i]);
        end
    endfunction

    function automatic void push_char(logic [7:0] ch, logic fin);
        char_item_t it;
        it.ch = ch;
        it.fin = fin;
        it.typed = 1'b0;
        it.nbytes = 0;
        it.bytes = '{8'h00, 8'h00, 8'h00};
        stim_q.insert(stim_q.size(), it);
    endfunction

    function automatic void add_message();
        int first;
        int groups;
        int tail;
        first = stim_q.size();
        if ($urandom_range(0, 9) < 7) begin
            groups = $urandom_range(0, 4);
            tail = $urandom_range(0, 3);
            repeat (groups * 4 + tail) push_char(alpha_char($urandom_range(0, 63)), 1'b0);
            if (tail >= 2 && $urandom_range(0, 1) == 1) begin
                repeat (4 - tail) push_char(CHAR_PAD, 1'b0);
            end else if ($urandom_range(0, 4) == 0) begin
                push_char(8'($urandom), 1'b0);
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) push_char(alpha_char($urandom_range(0, 63)), 1'b0);
            end
        end else begin
            repeat ($urandom_range(1, 10)) push_char(8'($urandom), $urandom_range(0, 9) == 0);
        end
        if (stim_q.size() == first) begin
            push_char(alpha_char($urandom_range(0, 63)), 1'b0);
        end
        stim_q[stim_q.size() - 1].fin = 1'b1;
    endfunction

    initial begin
        logic [15:0] pattern;
        int          span;
        pattern = '1;
        span = 0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                case ($urandom_range(0, 3))
                    0: pattern = '1;
                    1: pattern = 16'($urandom);
                    2: pattern = 16'($urandom & $urandom) | 16'h0001;
                    default: pattern = 16'($urandom | $urandom);
                endcase
                span = $urandom_range(16, 128);
            end
            m_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
            span--;
        end
    end

    always @(posedge aclk) begin
        decoded_byte_t got;
        decoded_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_data_out, m_byte_valid, m_message_end, m_last_in_run};
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got data=%h bv=%b end=%b last=%b",
                         $time, got.data, got.byte_valid, got.message_end, got.last_in_run);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    $display("%0t: expected data=%h bv=%b end=%b last=%b, got data=%h bv=%b end=%b last=%b",
                             $time, want.data, want.byte_valid, want.message_end,
                             want.last_in_run, got.data, got.byte_valid, got.message_end,
                             got.last_in_run);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int         burst_left;
        char_item_t it;
        burst_left = 0;
        grp_count = 2'd0;
        grp_sextets = '{6'd0, 6'd0, 6'd0};
        halted = 1'b0;
        foreach (directed_rows[i]) begin
            stim_q.insert(stim_q.size(), directed_rows[i]);
        end
        while (stim_q.size() < $size(directed_rows) + RANDOM_CHARS) begin
            add_message();
        end
        while (aresetn !== 1'b1) @(posedge aclk);
        foreach (stim_q[i]) begin
            it = stim_q[i];
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            end
            s_valid <= 1'b1;
            s_text_char <= it.ch;
            s_final_char <= it.fin;
            do @(posedge aclk); while (!s_ready);
            predict_char(it.ch, it.fin);
            if (it.typed) begin
                push_typed(it);
            end else begin
                foreach (step_out[j]) begin
                    pending_bytes.insert(pending_bytes.size(), step_out[j]);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
